### design/tun_pkg.sv
// Shared types and widths for the triangle unit-normal pipeline.
package tun_pkg;

	localparam int EW  = 33;        // edge component
	localparam int PW  = 66;        // edge product
	localparam int CW  = 67;        // cross component, signed
	localparam int MW  = 66;        // cross magnitude
	localparam int HW  = 33;        // half of a magnitude for squaring
	localparam int SQW = 130;       // one square
	localparam int SW  = 132;       // sum of squares
	localparam int RW  = 198;       // digit recurrence residual
	localparam int NB  = 31;        // result magnitude bits, Q1.30 up to 1.0
	localparam int RHS_SHIFT = 62;
	localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

	typedef struct packed {
		logic signed [31:0] p0_x;
		logic signed [31:0] p0_y;
		logic signed [31:0] p0_z;
		logic signed [31:0] p1_x;
		logic signed [31:0] p1_y;
		logic signed [31:0] p1_z;
		logic signed [31:0] p2_x;
		logic signed [31:0] p2_y;
		logic signed [31:0] p2_z;
	} tri_in_t;

	typedef struct packed {
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic               degenerate;
	} norm_out_t;

	// State carried through the digit stages
	typedef struct packed {
		logic [2:0][RW-1:0] r;      // a^2*2^62 - v^2*S, signed
		logic [2:0][RW-1:0] p;      // v*S, signed
		logic [2:0][NB-1:0] m;
		logic [2:0]         neg;
		logic [SW-1:0]      s;
		logic               degen;
	} dig_t;

endpackage

### design/tun_front.sv
// Front stages: edges, cross product, squares, sum and recurrence set-up.
module tun_front import tun_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  tri_in_t in_data,
	output logic    in_ready,
	output logic    out_valid,
	output dig_t    out_data,
	input  logic    out_ready
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv8;

	logic signed [EW-1:0] e1_s1 [3];
	logic signed [EW-1:0] e2_s1 [3];
	logic signed [PW-1:0] pr_s2 [6];
	logic signed [CW-1:0] c_s3 [3];
	logic [MW-1:0]        mag_s4 [3];
	logic [2:0]           neg_s4, neg_s5, neg_s6, neg_s7;
	logic [2*HW-1:0]      hh_s5 [3];
	logic [2*HW-1:0]      hl_s5 [3];
	logic [2*HW-1:0]      ll_s5 [3];
	logic [SQW-1:0]       sq_s6 [3];
	logic [SQW-1:0]       sq_s7 [3];
	logic [SW-1:0]        sum_s7;
	dig_t                 dig_s8;

	// a stage moves when it is empty or its successor moves
	assign adv8 = !valid_s8 || out_ready;
	assign adv7 = !valid_s7 || adv8;
	assign adv6 = !valid_s6 || adv7;
	assign adv5 = !valid_s5 || adv6;
	assign adv4 = !valid_s4 || adv5;
	assign adv3 = !valid_s3 || adv4;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign in_ready  = adv1;
	assign out_valid = valid_s8;
	assign out_data  = dig_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
			if (adv5) valid_s5 <= valid_s4;
			if (adv6) valid_s6 <= valid_s5;
			if (adv7) valid_s7 <= valid_s6;
			if (adv8) valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			e1_s1[0] <= EW'(in_data.p0_x) - EW'(in_data.p1_x);
			e1_s1[1] <= EW'(in_data.p0_y) - EW'(in_data.p1_y);
			e1_s1[2] <= EW'(in_data.p0_z) - EW'(in_data.p1_z);
			e2_s1[0] <= EW'(in_data.p1_x) - EW'(in_data.p2_x);
			e2_s1[1] <= EW'(in_data.p1_y) - EW'(in_data.p2_y);
			e2_s1[2] <= EW'(in_data.p1_z) - EW'(in_data.p2_z);
		end
		if (adv2) begin
			pr_s2[0] <= PW'(e1_s1[1]) * PW'(e2_s1[2]);
			pr_s2[1] <= PW'(e1_s1[2]) * PW'(e2_s1[1]);
			pr_s2[2] <= PW'(e1_s1[2]) * PW'(e2_s1[0]);
			pr_s2[3] <= PW'(e1_s1[0]) * PW'(e2_s1[2]);
			pr_s2[4] <= PW'(e1_s1[0]) * PW'(e2_s1[1]);
			pr_s2[5] <= PW'(e1_s1[1]) * PW'(e2_s1[0]);
		end
		if (adv3) begin
			for (int k = 0; k < 3; k++)
				c_s3[k] <= CW'(pr_s2[2*k]) - CW'(pr_s2[2*k+1]);
		end
		if (adv4) begin
			for (int k = 0; k < 3; k++) begin
				neg_s4[k] <= c_s3[k][CW-1];
				mag_s4[k] <= c_s3[k][CW-1] ? MW'(-c_s3[k]) : MW'(c_s3[k]);
			end
		end
		if (adv5) begin
			neg_s5 <= neg_s4;
			for (int k = 0; k < 3; k++) begin
				hh_s5[k] <= (2*HW)'(mag_s4[k][MW-1:HW]) * (2*HW)'(mag_s4[k][MW-1:HW]);
				hl_s5[k] <= (2*HW)'(mag_s4[k][MW-1:HW]) * (2*HW)'(mag_s4[k][HW-1:0]);
				ll_s5[k] <= (2*HW)'(mag_s4[k][HW-1:0]) * (2*HW)'(mag_s4[k][HW-1:0]);
			end
		end
		if (adv6) begin
			neg_s6 <= neg_s5;
			for (int k = 0; k < 3; k++)
				sq_s6[k] <= (SQW'(hh_s5[k]) << (2*HW)) + (SQW'(hl_s5[k]) << (HW+1))
					+ SQW'(ll_s5[k]);
		end
		if (adv7) begin
			neg_s7 <= neg_s6;
			sq_s7  <= sq_s6;
			sum_s7 <= SW'(sq_s6[0]) + SW'(sq_s6[1]) + SW'(sq_s6[2]);
		end
		if (adv8) begin
			// v starts at -1: residual a^2*2^62 - S, product -S
			for (int k = 0; k < 3; k++) begin
				dig_s8.r[k] <= (RW'(sq_s7[k]) << RHS_SHIFT) - RW'(sum_s7);
				dig_s8.p[k] <= RW'(0) - RW'(sum_s7);
				dig_s8.m[k] <= '0;
			end
			dig_s8.neg   <= neg_s7;
			dig_s8.s     <= sum_s7;
			dig_s8.degen <= (sum_s7 == '0);
		end
	end

endmodule

### design/tun_digit.sv
// One stage of the rounded quotient recurrence: settles one result bit per component.
module tun_digit import tun_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [4:0] pos,
	input  logic       in_valid,
	input  dig_t       in_data,
	output logic       in_ready,
	output logic       out_valid,
	output dig_t       out_data,
	input  logic       out_ready
);

	logic              valid_s1;
	dig_t              dig_s1;
	dig_t              nxt;
	logic [5:0]        sh_p;
	logic [5:0]        sh_s1;
	logic [6:0]        sh_s2;
	logic signed [RW-1:0] sx;
	logic signed [RW-1:0] pk   [3];
	logic signed [RW-1:0] rk   [3];
	logic signed [RW-1:0] diff [3];
	logic [2:0]        take;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = dig_s1;

	assign sh_p  = {1'b0, pos} + 6'd2;
	assign sh_s1 = {1'b0, pos} + 6'd1;
	assign sh_s2 = {1'b0, pos, 1'b0} + 7'd2;
	assign sx    = $signed(RW'(in_data.s));

	// trial bit widens v by 2^(pos+1): residual drops by v*S*2^(pos+2) + S*2^(2pos+2)
	always_comb begin
		nxt = in_data;
		for (int k = 0; k < 3; k++) begin
			pk[k]   = $signed(in_data.p[k]);
			rk[k]   = $signed(in_data.r[k]);
			diff[k] = rk[k] - (pk[k] <<< sh_p) - (sx <<< sh_s2);
			take[k] = !diff[k][RW-1];
			if (take[k]) begin
				nxt.r[k]      = diff[k];
				nxt.p[k]      = pk[k] + (sx <<< sh_s1);
				nxt.m[k][pos] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) dig_s1 <= nxt;
	end

endmodule

### design/tun_back.sv
// Output stage: applies the sign and the degenerate case to the settled magnitudes.
module tun_back import tun_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  dig_t      in_data,
	output logic      in_ready,
	output logic      out_valid,
	output norm_out_t out_data,
	input  logic      out_ready
);

	logic              valid_s1;
	norm_out_t         res_s1;
	logic signed [31:0] comp [3];

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = res_s1;

	// a zero sum leaves every trial bit set, so force zero here
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (in_data.degen)
				comp[k] = '0;
			else if (in_data.neg[k])
				comp[k] = 32'sd0 - $signed(32'(in_data.m[k]));
			else
				comp[k] = $signed(32'(in_data.m[k]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			res_s1.normal_x   <= comp[0];
			res_s1.normal_y   <= comp[1];
			res_s1.normal_z   <= comp[2];
			res_s1.degenerate <= in_data.degen;
		end
	end

endmodule

### design/triangle_unit_normal.sv
// Top level of the triangle unit-normal pipeline.
//
//  channel | signals                        | payload
//  in      | in_valid, in_ready, in_data    | tri_in_t, three corners Q16.16
//  out     | out_valid, out_ready, out_data | norm_out_t, unit normal Q1.30
//
// One triangle per cycle while out_ready is high. Path from input beat to output beat:
// 8 front stages (edges, cross, squares, sum, set-up), 31 digit stages, one output stage.
// Each digit stage settles one result bit of all three components with a wide
// residual subtract. Reset clears the valid bits only. Every stage holds while
// its successor is full and stalled; empty stages still fill, so nothing is lost.
module triangle_unit_normal import tun_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  tri_in_t   in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output norm_out_t out_data
);

	logic       vld   [NB+1];
	logic       rdy   [NB+1];
	dig_t       dig   [NB+1];
	logic       back_ready;

	tun_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.in_ready  (in_ready),
		.out_valid (vld[0]),
		.out_data  (dig[0]),
		.out_ready (rdy[0])
	);

	for (genvar i = 0; i < NB; i++) begin : g_digit
		tun_digit u_digit (
			.clk       (clk),
			.arst_n    (arst_n),
			.pos       (5'(NB - 1 - i)),
			.in_valid  (vld[i]),
			.in_data   (dig[i]),
			.in_ready  (rdy[i]),
			.out_valid (vld[i+1]),
			.out_data  (dig[i+1]),
			.out_ready (rdy[i+1])
		);
	end

	assign rdy[NB] = back_ready;

	tun_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld[NB]),
		.in_data   (dig[NB]),
		.in_ready  (back_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.out_ready (out_ready)
	);

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.degenerate |->
			out_data.normal_x == 0 && out_data.normal_y == 0 && out_data.normal_z == 0)
		else $error("degenerate beat with non-zero normal");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			out_data.normal_x <= ONE_Q30 && out_data.normal_x >= -ONE_Q30 &&
			out_data.normal_y <= ONE_Q30 && out_data.normal_y >= -ONE_Q30 &&
			out_data.normal_z <= ONE_Q30 && out_data.normal_z >= -ONE_Q30)
		else $error("normal component beyond one");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input refused while output side moves");

endmodule
